// ===== hw/rtl/gcs_pkg.sv =====
// ----------------------------------------------------------------------------
// gcs_pkg
// Shared widths, defaults and helpers for the greedy cover selector.
// ----------------------------------------------------------------------------
package gcs_pkg;

    // Fixed field widths
    localparam int ROW_W  = 32;  // row mask width
    localparam int CCNT_W = 6;   // column_count register width
    localparam int SEL_W  = 5;   // selected_row width
    localparam int PCNT_W = 6;   // popcount of a row, 0..32

    // Parameter defaults
    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_MAX_COLUMNS = 32;

    // column_count after reset
    localparam logic [CCNT_W-1:0] COLCNT_RESET = CCNT_W'(32);

    // Number of set bits in one row mask
    function automatic logic [PCNT_W-1:0] popcount(input logic [ROW_W-1:0] v);
        logic [PCNT_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < ROW_W; b++) begin
            acc = acc + PCNT_W'(v[b]);
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/greedy_cover_selector.sv =====
// ----------------------------------------------------------------------------
// greedy_cover_selector
// Loads a row coverage table and picks a greedy set cover over it.
// ----------------------------------------------------------------------------
// Rows load one per cycle into a row RAM; the row flagged last_row starts the
// selection, and the input is stalled until the final result of that run has
// been placed in the output register. Selection runs in rounds: each round
// reads every stored row once through the RAM's single read port and feeds it
// to one popcount-and-compare unit, then decides in the DECIDE state; that
// state waits while the output side stalls, unless it sends no beat. A run
// that picks K rows takes K+1 rounds. Chosen row indices come out in the
// order picked, the last one flagged; a run that picks nothing gives one beat
// flagged empty. column_count is sampled when the last row arrives.
// ----------------------------------------------------------------------------
module greedy_cover_selector #(
    parameter int MAX_ROWS    = gcs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = gcs_pkg::DEF_MAX_COLUMNS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [gcs_pkg::CCNT_W-1:0] i_cfg_data,
    // row input
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [gcs_pkg::ROW_W-1:0] i_row_bits,
    input  logic                      i_last_row,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [gcs_pkg::SEL_W-1:0] o_selected_row,
    output logic                      o_empty_cover,
    output logic                      o_last_selected
);

    import gcs_pkg::*;

    localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int COL_LIM = (MAX_COLUMNS < ROW_W) ? MAX_COLUMNS : ROW_W;
    localparam logic [CCNT_W-1:0] COL_LIM_V = CCNT_W'(COL_LIM);
    localparam logic [CNT_W-1:0]  ROWS_V    = CNT_W'(MAX_ROWS);

    // Sequencer states
    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    // Control registers
    logic [1:0]        r_state, n_state;
    logic [CCNT_W-1:0] r_column_count, n_column_count;
    logic [CNT_W-1:0]  r_row_total, n_row_total;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic              r_dv, n_dv;
    logic [PCNT_W-1:0] r_best_cnt, n_best_cnt;
    logic              r_have_pend, n_have_pend;
    logic              r_out_valid, n_out_valid;

    // Payload registers
    logic [RIDX_W-1:0] r_dv_idx, n_dv_idx;
    logic [RIDX_W-1:0] r_best_idx, n_best_idx;
    logic [ROW_W-1:0]  r_best_bits, n_best_bits;
    logic [ROW_W-1:0]  r_cmask, n_cmask;
    logic [ROW_W-1:0]  r_covered, n_covered;
    logic [RIDX_W-1:0] r_pend_idx, n_pend_idx;
    logic [SEL_W-1:0]  r_out_sel, n_out_sel;
    logic              r_out_empty, n_out_empty;
    logic              r_out_last, n_out_last;

    // Datapath wires
    logic              in_acc;
    logic              ram_we;
    logic [RIDX_W-1:0] ram_waddr;
    logic [RIDX_W-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;
    logic              issue;
    logic              out_free;
    logic [ROW_W-1:0]  row_masked;
    logic [PCNT_W-1:0] row_cnt;
    logic [CCNT_W-1:0] eff_cols;
    logic [ROW_W-1:0]  col_mask;
    logic              found;
    logic [RIDX_W+SEL_W-1:0] pend_ext;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_LOAD);
    assign in_acc      = i_in_valid && (r_state == ST_LOAD);
    assign out_free    = !r_out_valid || !i_out_stall;

    // Row store write and scan read addressing
    assign ram_we    = in_acc && (r_row_total < ROWS_V);
    assign ram_waddr = r_row_total[RIDX_W-1:0];
    assign ram_raddr = r_rd_idx[RIDX_W-1:0];
    assign issue     = (r_state == ST_SCAN) && (r_rd_idx != r_row_total);

    gcs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_ROWS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_row_bits),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Column mask from the saturated column count
    assign eff_cols = (r_column_count > COL_LIM_V) ? COL_LIM_V : r_column_count;
    assign col_mask = (eff_cols >= CCNT_W'(ROW_W)) ? '1
                    : ((ROW_W'(1) << eff_cols) - ROW_W'(1));

    // Shared popcount and compare unit
    assign row_masked = ram_rdata & r_cmask;
    assign row_cnt    = popcount(row_masked & ~r_covered);
    assign found      = (r_best_cnt != '0);
    assign pend_ext   = {{SEL_W{1'b0}}, r_pend_idx};

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_column_count = r_column_count;
        n_row_total    = r_row_total;
        n_rd_idx       = r_rd_idx;
        n_dv           = 1'b0;
        n_best_cnt     = r_best_cnt;
        n_have_pend    = r_have_pend;
        n_out_valid    = r_out_valid && i_out_stall;
        n_dv_idx       = ram_raddr;
        n_best_idx     = r_best_idx;
        n_best_bits    = r_best_bits;
        n_cmask        = r_cmask;
        n_covered      = r_covered;
        n_pend_idx     = r_pend_idx;
        n_out_sel      = r_out_sel;
        n_out_empty    = r_out_empty;
        n_out_last     = r_out_last;

        if (i_cfg_valid) begin
            n_column_count = i_cfg_data;
        end

        case (r_state)
            ST_LOAD: begin
                if (in_acc) begin
                    if (r_row_total < ROWS_V) begin
                        n_row_total = r_row_total + CNT_W'(1);
                    end
                    if (i_last_row) begin
                        n_cmask     = col_mask;
                        n_covered   = '0;
                        n_best_cnt  = '0;
                        n_have_pend = 1'b0;
                        n_rd_idx    = '0;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_rd_idx = r_rd_idx + CNT_W'(1);
                    n_dv     = 1'b1;
                end
                // compare the row read last cycle against the best so far
                if (r_dv && (row_cnt > r_best_cnt)) begin
                    n_best_cnt  = row_cnt;
                    n_best_idx  = r_dv_idx;
                    n_best_bits = row_masked;
                end
                if (!issue && !r_dv) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // a beat goes out unless this is the first pick of the run
                if (out_free || (found && !r_have_pend)) begin
                    if (r_have_pend) begin
                        n_out_valid = 1'b1;
                        n_out_sel   = pend_ext[SEL_W-1:0];
                        n_out_empty = 1'b0;
                        n_out_last  = !found;
                    end else if (!found) begin
                        n_out_valid = 1'b1;
                        n_out_sel   = '0;
                        n_out_empty = 1'b1;
                        n_out_last  = 1'b1;
                    end
                    if (found) begin
                        n_pend_idx  = r_best_idx;
                        n_have_pend = 1'b1;
                        n_covered   = r_covered | r_best_bits;
                        n_best_cnt  = '0;
                        n_rd_idx    = '0;
                        n_state     = ST_SCAN;
                    end else begin
                        n_have_pend = 1'b0;
                        n_row_total = '0;
                        n_state     = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_LOAD;
            r_column_count <= COLCNT_RESET;
            r_row_total    <= '0;
            r_rd_idx       <= '0;
            r_dv           <= 1'b0;
            r_best_cnt     <= '0;
            r_have_pend    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_column_count <= n_column_count;
            r_row_total    <= n_row_total;
            r_rd_idx       <= n_rd_idx;
            r_dv           <= n_dv;
            r_best_cnt     <= n_best_cnt;
            r_have_pend    <= n_have_pend;
            r_out_valid    <= n_out_valid;
        end
    end

    // Datapath and output payload
    always_ff @(posedge i_clk) begin
        r_dv_idx    <= n_dv_idx;
        r_best_idx  <= n_best_idx;
        r_best_bits <= n_best_bits;
        r_cmask     <= n_cmask;
        r_covered   <= n_covered;
        r_pend_idx  <= n_pend_idx;
        r_out_sel   <= n_out_sel;
        r_out_empty <= n_out_empty;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_selected_row  = r_out_sel;
    assign o_empty_cover   = r_out_empty;
    assign o_last_selected = r_out_last;

endmodule

// ===== hw/rtl/gcs_ram.sv =====
// ----------------------------------------------------------------------------
// gcs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
